### rtl/core/letterbox_nearest_scaler_address_defines.svh
// Assertion macros for the letterbox scaler address block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LETTERBOX_NEAREST_SCALER_ADDRESS_DEFINES_SVH
`define LETTERBOX_NEAREST_SCALER_ADDRESS_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define LNSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define LNSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lnsa_pkg.sv
// Shared widths, types and helpers for the letterbox scaler address block.
// No dependencies; used by the divider, the axis datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lnsa_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;  // holds 1..MAX_DIM
  localparam int COORD_W     = 12;  // pixel coordinate
  localparam int CONT_W      = 25;  // content length, up to MAX_DIM*MAX_DIM
  localparam int RECIP_SHIFT = 25;  // reciprocal scale, 2^RECIP_SHIFT / content
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_W       = 26;  // dividend and quotient width
  localparam int DIVR_W      = 25;  // divisor width
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int AXIS_STAGES = 4;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_FIT_H      = 3'd4,
    REG_FIT_V      = 3'd5
  } cfg_reg_e;

  // Per-axis constants derived by the setup sequencer
  typedef struct packed {
    logic [DIM_W-1:0]   dsz;    // screen size
    logic [DIM_W-1:0]   ssz;    // source size
    logic [CONT_W-1:0]  csz;    // content size on screen
    logic [COORD_W-1:0] off;    // centering offset
    logic [RECIP_W-1:0] recip;  // floor(2^RECIP_SHIFT / csz)
  } axis_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Zero reads as one, anything above MAX_DIM saturates
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/letterbox_nearest_scaler_address.sv
// Top level of the letterbox nearest-neighbor scaler address generator.
// Depends on lnsa_pkg, lnsa_div, lnsa_axis and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "letterbox_nearest_scaler_address_defines.svh"

// Maps one screen coordinate per clock to the nearest source pixel, or flags it
// as border (to be filled with 0x77, with both coordinates returned as zero).
// Throughput is one word per cycle while m_axis_tready is high and setup is idle;
// each word passes the four-stage per-axis pipeline (border test, scale,
// reciprocal multiply, back-multiply and correct) and then the output register.
// After reset and after every configuration write, a setup sequencer derives
// content sizes, centering offsets and per-axis reciprocals with one shared
// serial divider (up to four divisions); s_axis_tready stays low until setup
// completes. Configuration writes are always accepted.
module letterbox_nearest_scaler_address (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input coordinate stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,   // dest_row[11:0], dest_col[23:12]
  // Source address stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,   // source_row[11:0], source_col[23:12]
  output logic                              m_axis_tuser,   // is_border[0]
  // Register write port
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lnsa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lnsa_pkg::DIM_W-1:0]        cfg_data_i
);
  import lnsa_pkg::*;

  localparam int NSTG = AXIS_STAGES + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FACT = 6'b000010,
    S_CONT = 6'b000100,
    S_RECW = 6'b001000,
    S_RECH = 6'b010000,
    S_OFFS = 6'b100000
  } setup_state_e;

  // Registers
  logic [DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic             fit_h_q, fit_v_q;
  logic             cfg_wr;

  // Setup sequencer
  setup_state_e       state_q, state_d;
  logic               go_q, go_d;
  logic               dirty_q, dirty_d;
  logic [DIM_W-1:0]   factor_q, factor_d;
  logic [CONT_W-1:0]  cw_q, cw_d, ch_q, ch_d;
  logic [RECIP_W-1:0] rw_q, rw_d, rh_q, rh_d;
  logic [COORD_W-1:0] offw_q, offw_d, offh_q, offh_d;
  logic               setup_busy;

  logic [DIM_W-1:0]   fs, fd, s_len;
  logic               one_fit, fs_gt;
  logic [2*DIM_W-1:0] prod;
  logic [CONT_W-1:0]  content;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Pipeline control
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;
  logic            in_acc;

  axis_cfg_t          cfg_row, cfg_col;
  logic [COORD_W-1:0] idx_row, idx_col;
  logic               brd_row, brd_col;
  logic [COORD_W-1:0] row_q, col_q;
  logic               border_q;

  // ---------------------------------------------------------------------------
  // Register file: store sizes already clamped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DIM_W'(1);
      src_height_q <= DIM_W'(1);
      dst_width_q  <= DIM_W'(1);
      dst_height_q <= DIM_W'(1);
      fit_h_q      <= 1'b0;
      fit_v_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  src_width_q  <= clamp_size(cfg_data_i);
        REG_SRC_HEIGHT: src_height_q <= clamp_size(cfg_data_i);
        REG_DST_WIDTH:  dst_width_q  <= clamp_size(cfg_data_i);
        REG_DST_HEIGHT: dst_height_q <= clamp_size(cfg_data_i);
        REG_FIT_H:      fit_h_q      <= cfg_data_i[0];
        REG_FIT_V:      fit_v_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Fitted axis drives the scale factor; the other axis follows it
  assign one_fit = fit_h_q ^ fit_v_q;
  assign fs      = fit_h_q ? src_width_q  : src_height_q;
  assign fd      = fit_h_q ? dst_width_q  : dst_height_q;
  assign s_len   = fit_h_q ? src_height_q : src_width_q;
  assign fs_gt   = fs > fd;
  assign prod    = (2*DIM_W)'(s_len) * (2*DIM_W)'(div_rsp.quotient[DIM_W-1:0]);

  // Divider operands per setup step
  always_comb begin
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_FACT: begin
        div_req.dividend = DIV_W'(fs_gt ? fs : fd);
        div_req.divisor  = DIVR_W'(fs_gt ? fd : fs);
      end
      S_CONT: begin
        div_req.dividend = DIV_W'(s_len);
        div_req.divisor  = DIVR_W'(factor_q);
      end
      S_RECW: begin
        div_req.dividend = DIV_W'(1) << RECIP_SHIFT;
        div_req.divisor  = cw_q;
      end
      S_RECH: begin
        div_req.dividend = DIV_W'(1) << RECIP_SHIFT;
        div_req.divisor  = ch_q;
      end
      default: ;
    endcase
    div_req.start = go_q && (div_req.divisor != '0);
  end

  lnsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequence: factor and scaled content (only when one axis fits), two reciprocals, offsets
  always_comb begin
    state_d  = state_q;
    go_d     = 1'b0;
    dirty_d  = dirty_q;
    factor_d = factor_q;
    cw_d     = cw_q;
    ch_d     = ch_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    offw_d   = offw_q;
    offh_d   = offh_q;
    content  = (state_q == S_CONT) ? div_rsp.quotient[CONT_W-1:0] : prod[CONT_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (dirty_q) begin
          dirty_d = 1'b0;
          go_d    = 1'b1;
          if (one_fit) begin
            state_d = S_FACT;
          end else begin
            // Both fit bits agree: stretch to the screen or keep source size
            cw_d    = CONT_W'(fit_h_q ? dst_width_q  : src_width_q);
            ch_d    = CONT_W'(fit_h_q ? dst_height_q : src_height_q);
            state_d = S_RECW;
          end
        end
      end
      S_FACT: begin
        if (div_rsp.done) begin
          factor_d = div_rsp.quotient[DIM_W-1:0];
          go_d     = 1'b1;
          if (fs_gt) begin
            state_d = S_CONT;
          end else begin
            state_d = S_RECW;
            if (fit_h_q) begin
              cw_d = CONT_W'(dst_width_q);
              ch_d = content;
            end else begin
              cw_d = content;
              ch_d = CONT_W'(dst_height_q);
            end
          end
        end
      end
      S_CONT: begin
        if (div_rsp.done) begin
          go_d    = 1'b1;
          state_d = S_RECW;
          if (fit_h_q) begin
            cw_d = CONT_W'(dst_width_q);
            ch_d = content;
          end else begin
            cw_d = content;
            ch_d = CONT_W'(dst_height_q);
          end
        end
      end
      S_RECW: begin
        if (go_q && (cw_q == '0)) begin
          rw_d    = '0;
          go_d    = 1'b1;
          state_d = S_RECH;
        end else if (div_rsp.done) begin
          rw_d    = div_rsp.quotient[RECIP_W-1:0];
          go_d    = 1'b1;
          state_d = S_RECH;
        end
      end
      S_RECH: begin
        if (go_q && (ch_q == '0)) begin
          rh_d    = '0;
          state_d = S_OFFS;
        end else if (div_rsp.done) begin
          rh_d    = div_rsp.quotient[RECIP_W-1:0];
          state_d = S_OFFS;
        end
      end
      S_OFFS: begin
        // Center content that is narrower than the screen
        offw_d  = (cw_q < CONT_W'(dst_width_q))
                  ? COORD_W'((CONT_W'(dst_width_q) - cw_q) >> 1) : '0;
        offh_d  = (ch_q < CONT_W'(dst_height_q))
                  ? COORD_W'((CONT_W'(dst_height_q) - ch_q) >> 1) : '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // A write always forces a fresh pass
    if (cfg_wr) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      dirty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    cw_q     <= cw_d;
    ch_q     <= ch_d;
    rw_q     <= rw_d;
    rh_q     <= rh_d;
    offw_q   <= offw_d;
    offh_q   <= offh_d;
  end

  assign setup_busy = dirty_q || (state_q != S_IDLE);

  // ---------------------------------------------------------------------------
  // Per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0] && !setup_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_acc;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Axis datapaths
  assign cfg_row = '{dsz: dst_height_q, ssz: src_height_q, csz: ch_q,
                     off: offh_q, recip: rh_q};
  assign cfg_col = '{dsz: dst_width_q, ssz: src_width_q, csz: cw_q,
                     off: offw_q, recip: rw_q};

  lnsa_axis u_axis_row (
    .clk_i    (clk_i),
    .en_i     (en[AXIS_STAGES-1:0]),
    .cfg_i    (cfg_row),
    .d_i      (s_axis_tdata[COORD_W-1:0]),
    .idx_o    (idx_row),
    .border_o (brd_row)
  );

  lnsa_axis u_axis_col (
    .clk_i    (clk_i),
    .en_i     (en[AXIS_STAGES-1:0]),
    .cfg_i    (cfg_col),
    .d_i      (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .idx_o    (idx_col),
    .border_o (brd_col)
  );

  // Output register: border on either axis zeroes both coordinates
  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      border_q <= brd_row || brd_col;
      row_q    <= (brd_row || brd_col) ? '0 : idx_row;
      col_q    <= (brd_row || brd_col) ? '0 : idx_col;
    end
  end

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {col_q, row_q};
  assign m_axis_tuser  = border_q;

  // ---------------------------------------------------------------------------
  // Checks
  `LNSA_ASSERT_IMPL(a_border_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "border word carries nonzero coordinates")
  `LNSA_ASSERT_IMPL(a_col_in_range, m_axis_tvalid && !m_axis_tuser, {1'b0, m_axis_tdata[23:12]} < src_width_q, "source column beyond source width")
  `LNSA_ASSERT_IMPL(a_div_owner, div_rsp.done, state_q == S_FACT || state_q == S_CONT || state_q == S_RECW || state_q == S_RECH, "divider result with no setup step waiting")
  `LNSA_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid_i && cfg_ready_o, !s_axis_tready, "input accepted before setup reran")

endmodule

`default_nettype wire

### rtl/core/lnsa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lnsa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module lnsa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lnsa_pkg::div_req_t req_i,
  output lnsa_pkg::div_rsp_t rsp_o
);
  import lnsa_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVR_W-1:0]    dsr_q, dsr_d;
  logic [DIVR_W:0]      rem_sh;
  logic                 fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DIVR_W'(rem_sh - {1'b0, dsr_q}) : DIVR_W'(rem_sh);
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath needs no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### rtl/core/lnsa_axis.sv
// Four-stage pipelined coordinate map for one axis: border test, scale,
// reciprocal divide with one correction step. Depends on lnsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lnsa_axis (
  input  logic                                clk_i,
  input  logic [lnsa_pkg::AXIS_STAGES-1:0]    en_i,
  input  lnsa_pkg::axis_cfg_t                 cfg_i,
  input  logic [lnsa_pkg::COORD_W-1:0]        d_i,
  output logic [lnsa_pkg::COORD_W-1:0]        idx_o,
  output logic                                border_o
);
  import lnsa_pkg::*;

  localparam int P3_W = CONT_W + RECIP_W;
  localparam int P4_W = CONT_W + DIM_W;

  logic               b1_q, b2_q, b3_q, b4_q;
  logic [COORD_W-1:0] x1_q;
  logic [CONT_W-1:0]  n2_q, n3_q, n4_q;
  logic [DIM_W-1:0]   q3_q, q4_q;
  logic [CONT_W-1:0]  m4_q;

  logic [P3_W-1:0]    p3;
  logic [P4_W-1:0]    p4;
  logic [CONT_W-1:0]  rem;
  logic [DIM_W-1:0]   q_fix, q_lim, q_out;

  // Stage 1: outside the screen, empty content, or left of the content
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      b1_q <= ({1'b0, d_i} >= cfg_i.dsz) || (cfg_i.csz == '0) || (d_i < cfg_i.off);
      x1_q <= d_i - cfg_i.off;
    end
  end

  // Stage 2: right of the content; scale by source size
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      b2_q <= b1_q || (CONT_W'(x1_q) >= cfg_i.csz);
      n2_q <= CONT_W'(x1_q) * CONT_W'(cfg_i.ssz);
    end
  end

  // Stage 3: estimate quotient through the reciprocal, low by at most one
  assign p3 = P3_W'(n2_q) * P3_W'(cfg_i.recip);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      b3_q <= b2_q;
      n3_q <= n2_q;
      q3_q <= p3[RECIP_SHIFT +: DIM_W];
    end
  end

  // Stage 4: back-multiply the estimate
  assign p4 = P4_W'(q3_q) * P4_W'(cfg_i.csz);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      b4_q <= b3_q;
      n4_q <= n3_q;
      q4_q <= q3_q;
      m4_q <= p4[CONT_W-1:0];
    end
  end

  // Correct the estimate, clamp to the last source pixel, zero on border
  assign rem   = n4_q - m4_q;
  assign q_fix = (rem >= cfg_i.csz) ? q4_q + DIM_W'(1) : q4_q;
  assign q_lim = cfg_i.ssz - DIM_W'(1);
  assign q_out = (q_fix > q_lim) ? q_lim : q_fix;

  assign idx_o    = b4_q ? '0 : q_out[COORD_W-1:0];
  assign border_o = b4_q;

endmodule

`default_nettype wire
